@@ hdl/sfc_pkg.sv @@
// Shared types and constants of the sphere frustum cull unit.
package sfc_pkg;

   // Planes per frustum and the fixed widths of the stream fields.
   localparam int PLANES       = 6;
   localparam int COEF_W       = 32;
   localparam int RADIUS_W     = 31;
   localparam int SLOT_W       = 3;
   localparam int ACTION_W     = 2;
   localparam int MASK_W       = 8;
   localparam int REQ_DATA_W   = 264;

   // Bit positions of the request fields inside req_tdata.
   localparam int FRUSTUM_LSB  = 0;
   localparam int PLANE_LSB    = 3;
   localparam int COEF_A_LSB   = 6;
   localparam int COEF_B_LSB   = 38;
   localparam int COEF_C_LSB   = 70;
   localparam int COEF_D_LSB   = 102;
   localparam int POINT_X_LSB  = 134;
   localparam int POINT_Y_LSB  = 166;
   localparam int POINT_Z_LSB  = 198;
   localparam int RADIUS_LSB   = 230;

   // Request kinds carried in req_tuser.
   typedef enum logic [ACTION_W-1:0] {
      ACT_CLEAR = 2'd0,
      ACT_LOAD  = 2'd1,
      ACT_TEST  = 2'd2,
      ACT_NONE  = 2'd3
   } action_type;

   // Controller states.
   typedef enum logic [1:0] {
      ST_IDLE  = 2'd0,
      ST_SWEEP = 2'd1,
      ST_DRAIN = 2'd2,
      ST_REPLY = 2'd3
   } state_type;

   // One stored plane, a in the lowest bits.
   typedef struct packed {
      logic signed [COEF_W-1:0] d;
      logic signed [COEF_W-1:0] c;
      logic signed [COEF_W-1:0] b;
      logic signed [COEF_W-1:0] a;
   } plane_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic wr_en;    // write the request's plane into the store
      logic capture;  // latch the test point and reset the pass flags
      logic rd_en;    // read one plane and send it down the pipeline
      logic rd_last;  // the plane read now is the last one of the sweep
      logic publish;  // load the result mask into the output register
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic done;     // the last plane distance has been evaluated
   } dp_status_type;

endpackage

@@ hdl/sfc_datapath.sv @@
// Plane store and the plane distance pipeline of the sphere frustum cull unit.
module sfc_datapath
   import sfc_pkg::*;
#(
   parameter int FRUSTUMS = 8,
   parameter int ADDR_W   = 6
) (
   input  logic                       clock,
   input  logic                       reset,
   input  dp_cmd_type                 cmd,
   output dp_status_type              status,
   input  logic [ADDR_W-1:0]          wr_addr,
   input  logic [ADDR_W-1:0]          rd_addr,
   input  logic [FRUSTUMS-1:0]        rd_sel,
   input  logic [FRUSTUMS-1:0]        valid_mask,
   input  logic signed [COEF_W-1:0]   coef_a,
   input  logic signed [COEF_W-1:0]   coef_b,
   input  logic signed [COEF_W-1:0]   coef_c,
   input  logic signed [COEF_W-1:0]   coef_d,
   input  logic signed [COEF_W-1:0]   point_x,
   input  logic signed [COEF_W-1:0]   point_y,
   input  logic signed [COEF_W-1:0]   point_z,
   input  logic [RADIUS_W-1:0]        radius,
   output logic [MASK_W-1:0]          visible_mask
);

   localparam int DEPTH = FRUSTUMS * PLANES;
   localparam int OFF_W = COEF_W + 17;

   // Plane store: one write port for loads, one registered read port for the sweep.
   plane_type plane_mem [DEPTH];
   plane_type rd_plane_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         plane_mem[wr_addr] <= '{d: coef_d, c: coef_c, b: coef_b, a: coef_a};
      end
      if (cmd.rd_en) begin
         rd_plane_ff <= plane_mem[rd_addr];
      end
   end

   // Test point held for the whole sweep.
   logic signed [COEF_W-1:0] px_ff, py_ff, pz_ff;
   logic [RADIUS_W-1:0]      radius_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         px_ff     <= point_x;
         py_ff     <= point_y;
         pz_ff     <= point_z;
         radius_ff <= radius;
      end
   end

   // Pipeline control: valid, last and frustum select travel with each plane.
   logic                v0_ff, v1_ff, v2_ff;
   logic                last0_ff, last1_ff, last2_ff;
   logic [FRUSTUMS-1:0] sel0_ff, sel1_ff, sel2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v0_ff <= cmd.rd_en;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      last0_ff <= cmd.rd_last;
      last1_ff <= last0_ff;
      last2_ff <= last1_ff;
      sel0_ff  <= rd_sel;
      sel1_ff  <= sel0_ff;
      sel2_ff  <= sel1_ff;
   end

   // Stage one: three products and the offset d - r, scaled by 2^16 to match the products.
   logic signed [2*COEF_W-1:0] prod_a_in, prod_b_in, prod_c_in;
   logic signed [2*COEF_W-1:0] prod_a_ff, prod_b_ff, prod_c_ff;
   logic signed [OFF_W-1:0]    d_ext, r_ext, off_in, off_ff;

   always_comb begin
      prod_a_in = (2*COEF_W)'(rd_plane_ff.a) * (2*COEF_W)'(px_ff);
      prod_b_in = (2*COEF_W)'(rd_plane_ff.b) * (2*COEF_W)'(py_ff);
      prod_c_in = (2*COEF_W)'(rd_plane_ff.c) * (2*COEF_W)'(pz_ff);
      d_ext     = OFF_W'($signed({rd_plane_ff.d, 16'h0000}));
      r_ext     = $signed(OFF_W'({radius_ff, 16'h0000}));
      off_in    = d_ext - r_ext;
   end

   always_ff @(posedge clock) begin
      prod_a_ff <= prod_a_in;
      prod_b_ff <= prod_b_in;
      prod_c_ff <= prod_c_in;
      off_ff    <= off_in;
   end

   // Stage two: pairwise sums.
   logic signed [2*COEF_W:0] sum_ab_in, sum_cd_in, sum_ab_ff, sum_cd_ff;

   always_comb begin
      sum_ab_in = (2*COEF_W+1)'(prod_a_ff) + (2*COEF_W+1)'(prod_b_ff);
      sum_cd_in = (2*COEF_W+1)'(prod_c_ff) + (2*COEF_W+1)'(off_ff);
   end

   always_ff @(posedge clock) begin
      sum_ab_ff <= sum_ab_in;
      sum_cd_ff <= sum_cd_in;
   end

   // Stage three: final sum; a positive distance beyond the radius fails the frustum.
   logic signed [2*COEF_W+1:0] total;
   logic                       plane_fail;
   logic [FRUSTUMS-1:0]        pass_ff, pass_in;

   always_comb begin
      total      = (2*COEF_W+2)'(sum_ab_ff) + (2*COEF_W+2)'(sum_cd_ff);
      plane_fail = !total[2*COEF_W+1] && (total != '0);
      pass_in    = pass_ff;
      if (cmd.capture) begin
         pass_in = '1;
      end else if (v2_ff && plane_fail) begin
         pass_in = pass_ff & ~sel2_ff;
      end
   end

   always_ff @(posedge clock) begin
      pass_ff <= pass_in;
   end

   assign status.done = v2_ff && last2_ff;

   // Output register, loaded when the controller hands the result over.
   logic [MASK_W-1:0] mask_full;
   logic [MASK_W-1:0] visible_mask_ff;

   always_comb begin
      mask_full                 = '0;
      mask_full[FRUSTUMS-1:0]   = pass_ff & valid_mask;
   end

   always_ff @(posedge clock) begin
      if (cmd.publish) begin
         visible_mask_ff <= mask_full;
      end
   end

   assign visible_mask = visible_mask_ff;

endmodule

@@ hdl/sfc_controller.sv @@
// Sequencer of the sphere frustum cull unit: request decode, sweep and result handoff.
module sfc_controller
   import sfc_pkg::*;
#(
   parameter int FRUSTUMS = 8,
   parameter int ADDR_W   = 6
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [ACTION_W-1:0]   action,
   input  logic [SLOT_W-1:0]     frustum_slot,
   input  logic [SLOT_W-1:0]     plane_slot,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output dp_cmd_type            cmd,
   input  dp_status_type         status,
   output logic [ADDR_W-1:0]     wr_addr,
   output logic [ADDR_W-1:0]     rd_addr,
   output logic [FRUSTUMS-1:0]   rd_sel,
   output logic [FRUSTUMS-1:0]   valid_mask
);

   localparam int          DEPTH         = FRUSTUMS * PLANES;
   localparam logic [3:0]  FrustumCount  = 4'(FRUSTUMS);
   localparam logic [2:0]  LastPlane     = 3'(PLANES - 1);

   state_type           state_ff, state_in;
   logic [ADDR_W-1:0]   addr_ff, addr_in;
   logic [2:0]          plane_ff, plane_in;
   logic [FRUSTUMS-1:0] sel_ff, sel_in;
   logic [FRUSTUMS-1:0] valid_ff, valid_in;
   logic                rsp_tvalid_ff, rsp_tvalid_in;

   logic                accept;
   logic                load_ok;
   logic [5:0]          load_addr;
   logic                sweep_last;
   action_type          act;

   // Load address and range check.
   always_comb begin
      act       = action_type'(action);
      load_ok   = ({1'b0, frustum_slot} < FrustumCount) && (plane_slot <= LastPlane);
      load_addr = 6'(frustum_slot) * 6'(PLANES) + 6'(plane_slot);
      wr_addr   = load_addr[ADDR_W-1:0];
   end

   // State register and counters.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         valid_ff      <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         valid_ff      <= valid_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff  <= addr_in;
      plane_ff <= plane_in;
      sel_ff   <= sel_in;
   end

   // Next state and commands.
   always_comb begin
      state_in      = state_ff;
      addr_in       = addr_ff;
      plane_in      = plane_ff;
      sel_in        = sel_ff;
      valid_in      = valid_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      cmd           = '0;
      req_tready    = 1'b0;
      accept        = 1'b0;
      sweep_last    = (addr_ff == ADDR_W'(DEPTH - 1));

      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            accept     = req_tvalid;
            if (accept) begin
               unique case (act)
                  ACT_CLEAR: begin
                     valid_in = '0;
                  end
                  ACT_LOAD: begin
                     if (load_ok) begin
                        cmd.wr_en = 1'b1;
                        if (plane_slot == LastPlane) begin
                           for (int i = 0; i < FRUSTUMS; i++) begin
                              if (frustum_slot == SLOT_W'(i)) begin
                                 valid_in[i] = 1'b1;
                              end
                           end
                        end
                     end
                  end
                  ACT_TEST: begin
                     cmd.capture = 1'b1;
                     addr_in     = '0;
                     plane_in    = '0;
                     sel_in      = FRUSTUMS'(1);
                     state_in    = ST_SWEEP;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SWEEP: begin
            // One plane per cycle, frustum by frustum.
            cmd.rd_en   = 1'b1;
            cmd.rd_last = sweep_last;
            addr_in     = addr_ff + ADDR_W'(1);
            if (plane_ff == LastPlane) begin
               plane_in = '0;
               sel_in   = sel_ff << 1;
            end else begin
               plane_in = plane_ff + 3'd1;
            end
            if (sweep_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (status.done) begin
               state_in = ST_REPLY;
            end
         end
         ST_REPLY: begin
            // Wait for the output register to be free.
            if (!rsp_tvalid_ff || rsp_tready) begin
               cmd.publish   = 1'b1;
               rsp_tvalid_in = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rd_addr    = addr_ff;
   assign rd_sel     = sel_ff;
   assign valid_mask = valid_ff;
   assign rsp_tvalid = rsp_tvalid_ff;

   // The pipeline finishes only after the sweep has been issued.
   assert property (@(posedge clock) disable iff (reset)
      status.done |-> state_ff == ST_DRAIN)
      else $error("sweep result arrived outside the drain phase");

   // A new result appears only from the handoff state.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid_ff) |-> $past(state_ff) == ST_REPLY)
      else $error("result raised without a finished sweep");

   // Frustum valid bits change only by a clear or load taken while idle.
   assert property (@(posedge clock) disable iff (reset)
      !$stable(valid_ff) |-> $past(state_ff) == ST_IDLE && $past(accept))
      else $error("frustum valid bits changed outside a request transfer");

   // Exactly one frustum is selected throughout the sweep.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SWEEP |-> $onehot(sel_ff))
      else $error("frustum select lost its single bit during the sweep");

endmodule

@@ hdl/sphere_frustum_cull_unit.sv @@
// Top level of the sphere frustum cull unit: stream ports, controller and datapath.
//
// Keeps up to FRUSTUMS frustums of six planes (a, b, c, d in signed Q16.16) and tests
// spheres against them. A clear or plane load is taken in the idle state and the next
// request transfer can follow at once. A test reads the plane store one plane per cycle
// through its single read port, every frustum in turn, then lets the pipeline drain and
// hands the mask over; requests are not taken during a test. The result mask waits in an
// output register, so a following clear or load is taken while it is still pending.
// Each distance a*x+b*y+c*z+d is exact; a frustum is visible when it is valid and no
// distance exceeds the radius.
module sphere_frustum_cull_unit
   import sfc_pkg::*;
#(
   parameter int FRUSTUMS = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // frustum_slot, plane_slot, coef_a, coef_b, coef_c, coef_d, point_x, point_y,
   // point_z, radius (from bit 0 up), zero padded to 264 bits
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   // action
   input  logic [ACTION_W-1:0]    req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // visible_mask
   output logic [MASK_W-1:0]      rsp_tdata
);

   localparam int ADDR_W = $clog2(FRUSTUMS * PLANES);

   dp_cmd_type          cmd;
   dp_status_type       status;
   logic [ADDR_W-1:0]   wr_addr, rd_addr;
   logic [FRUSTUMS-1:0] rd_sel, valid_mask;

   // Request fields.
   logic [SLOT_W-1:0]        frustum_slot, plane_slot;
   logic signed [COEF_W-1:0] coef_a, coef_b, coef_c, coef_d;
   logic signed [COEF_W-1:0] point_x, point_y, point_z;
   logic [RADIUS_W-1:0]      radius;

   always_comb begin
      frustum_slot = req_tdata[FRUSTUM_LSB +: SLOT_W];
      plane_slot   = req_tdata[PLANE_LSB +: SLOT_W];
      coef_a       = req_tdata[COEF_A_LSB +: COEF_W];
      coef_b       = req_tdata[COEF_B_LSB +: COEF_W];
      coef_c       = req_tdata[COEF_C_LSB +: COEF_W];
      coef_d       = req_tdata[COEF_D_LSB +: COEF_W];
      point_x      = req_tdata[POINT_X_LSB +: COEF_W];
      point_y      = req_tdata[POINT_Y_LSB +: COEF_W];
      point_z      = req_tdata[POINT_Z_LSB +: COEF_W];
      radius       = req_tdata[RADIUS_LSB +: RADIUS_W];
   end

   sfc_controller #(
      .FRUSTUMS (FRUSTUMS),
      .ADDR_W   (ADDR_W)
   ) u_controller (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .action       (req_tuser),
      .frustum_slot (frustum_slot),
      .plane_slot   (plane_slot),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .cmd          (cmd),
      .status       (status),
      .wr_addr      (wr_addr),
      .rd_addr      (rd_addr),
      .rd_sel       (rd_sel),
      .valid_mask   (valid_mask)
   );

   sfc_datapath #(
      .FRUSTUMS (FRUSTUMS),
      .ADDR_W   (ADDR_W)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .wr_addr      (wr_addr),
      .rd_addr      (rd_addr),
      .rd_sel       (rd_sel),
      .valid_mask   (valid_mask),
      .coef_a       (coef_a),
      .coef_b       (coef_b),
      .coef_c       (coef_c),
      .coef_d       (coef_d),
      .point_x      (point_x),
      .point_y      (point_y),
      .point_z      (point_z),
      .radius       (radius),
      .visible_mask (rsp_tdata)
   );

endmodule

@@ bench/tb.sv @@
// Self-checking stream testbench for the sphere frustum cull unit, with its own visibility predictor.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import sfc_pkg::*;

   localparam int     FRUSTUMS      = 8;
   localparam int     HALF_PERIOD   = 6;
   localparam int     RESET_CYCLES  = 8;
   localparam int     TARGET_ITEMS  = 1750;
   localparam int     IDLE_PCT      = 26;
   localparam int     HOLD_AT       = 300;
   localparam int     HOLD_CYCLES   = 400;
   localparam int     CALM_FROM     = 900;
   localparam int     CALM_TO       = 1150;
   localparam int     SETTLE_CYCLES = 100;
   localparam int     DRAIN_LIMIT   = 20000;
   localparam longint TIMEOUT_NS    = 12_000_000;
   localparam int     UNIT          = 65536;

   typedef logic signed [COEF_W-1:0] coef_type;
   typedef logic signed [71:0]       wide_type;

   localparam coef_type            CMIN = 32'sh8000_0000;
   localparam coef_type            CMAX = 32'sh7FFF_FFFF;
   localparam logic [RADIUS_W-1:0] RMAX = '1;

   // One request as it travels on the input stream.
   typedef struct {
      action_type          action;
      logic [SLOT_W-1:0]   frustum_slot;
      logic [SLOT_W-1:0]   plane_slot;
      plane_type           plane;
      coef_type            point_x;
      coef_type            point_y;
      coef_type            point_z;
      logic [RADIUS_W-1:0] radius;
      bit                  drain_first;
   } cull_req_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // frustum_slot, plane_slot, coef_a, coef_b, coef_c, coef_d, point_x, point_y,
   // point_z, radius (from bit 0 up), zero padded
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   // action
   logic [ACTION_W-1:0]   req_tuser  = ACT_NONE;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // visible_mask
   logic [MASK_W-1:0]     rsp_tdata;

   // Request queue, expected masks and the predictor's copy of the frustum bank.
   cull_req_type        cull_requests[$];
   cull_req_type        on_bus;
   logic [MASK_W-1:0]   pending_masks[$];
   plane_type           plane_mem[FRUSTUMS*PLANES];
   logic [FRUSTUMS-1:0] frustum_live = '0;
   int                  req_xfers = 0;
   int                  errors = 0;
   logic                rsp_hold = 1'b0;
   logic                calm;

   // Stimulus bookkeeping: which planes were written and which frustums hold a known box.
   bit                  plane_written[FRUSTUMS*PLANES];
   int                  box_c[FRUSTUMS][3];
   int                  box_h[FRUSTUMS][3];
   bit                  box_known[FRUSTUMS];
   int                  items_made = 0;
   bit                  drain_next = 1'b0;

   assign calm = (req_xfers >= CALM_FROM) && (req_xfers < CALM_TO);

   sphere_frustum_cull_unit #(.FRUSTUMS(FRUSTUMS)) dut (.*);

   always #HALF_PERIOD clock = ~clock;

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
   end

   // True when no plane of frustum f puts the sphere farther out than its radius.
   function automatic bit sphere_inside(int f, coef_type x, coef_type y, coef_type z,
                                        logic [RADIUS_W-1:0] r);
      plane_type pl;
      wide_type  plane_dist;
      for (int p = 0; p < PLANES; p++) begin
         pl = plane_mem[f*PLANES + p];
         plane_dist = wide_type'($signed(pl.a)) * wide_type'(x)
                    + wide_type'($signed(pl.b)) * wide_type'(y)
                    + wide_type'($signed(pl.c)) * wide_type'(z)
                    + (wide_type'($signed(pl.d)) <<< 16)
                    - (wide_type'(r) <<< 16);
         if (plane_dist > 0) return 1'b0;
      end
      return 1'b1;
   endfunction

   // Applies one accepted request to the frustum bank and queues the mask a test yields.
   function automatic void predict_visibility(cull_req_type r);
      logic [MASK_W-1:0] mask;
      mask = '0;
      case (r.action)
         ACT_CLEAR: frustum_live = '0;
         ACT_LOAD: begin
            if (r.frustum_slot < FRUSTUMS && r.plane_slot < PLANES) begin
               plane_mem[r.frustum_slot*PLANES + r.plane_slot] = r.plane;
               if (r.plane_slot == PLANES-1) frustum_live[r.frustum_slot] = 1'b1;
            end
         end
         ACT_TEST: begin
            for (int f = 0; f < FRUSTUMS; f++)
               if (frustum_live[f] && sphere_inside(f, r.point_x, r.point_y, r.point_z, r.radius))
                  mask[f] = 1'b1;
            pending_masks = {pending_masks, mask};
         end
         default: ;
      endcase
   endfunction

   // A request of the given kind with every field random; callers overwrite what they use.
   function automatic cull_req_type random_req(action_type act);
      cull_req_type r;
      r.action       = act;
      r.frustum_slot = SLOT_W'($urandom);
      r.plane_slot   = SLOT_W'($urandom);
      r.plane        = {$urandom, $urandom, $urandom, $urandom};
      r.point_x      = $urandom;
      r.point_y      = $urandom;
      r.point_z      = $urandom;
      r.radius       = RADIUS_W'($urandom);
      r.drain_first  = 1'b0;
      return r;
   endfunction

   function automatic void push_req(cull_req_type r);
      r.drain_first = drain_next;
      drain_next = 1'b0;
      if (r.action == ACT_LOAD && r.plane_slot < PLANES)
         plane_written[r.frustum_slot*PLANES + r.plane_slot] = 1'b1;
      // Ignored requests do not count toward the item total.
      if (r.action != ACT_NONE && !(r.action == ACT_LOAD && r.plane_slot >= PLANES))
         items_made++;
      cull_requests = {cull_requests, r};
   endfunction

   function automatic void push_load(int f, int p, plane_type pl);
      cull_req_type r;
      r = random_req(ACT_LOAD);
      r.frustum_slot = SLOT_W'(f);
      r.plane_slot   = SLOT_W'(p);
      r.plane        = pl;
      push_req(r);
   endfunction

   function automatic void push_test(coef_type x, coef_type y, coef_type z,
                                     logic [RADIUS_W-1:0] rad);
      cull_req_type r;
      r = random_req(ACT_TEST);
      r.point_x = x;
      r.point_y = y;
      r.point_z = z;
      r.radius  = rad;
      push_req(r);
   endfunction

   // Plane p bounds one face of frustum f's box: even planes the upper side of an axis,
   // odd planes the lower side, with normal length m in Q16.16.
   function automatic plane_type box_plane(int f, int p, int m);
      plane_type pl;
      int        axis;
      int        sgn;
      longint    off;
      axis = p / 2;
      sgn  = (p % 2 == 0) ? 1 : -1;
      off  = -longint'(m) * (sgn * box_c[f][axis] + box_h[f][axis]);
      pl   = '0;
      case (axis)
         0:       pl.a = sgn * m;
         1:       pl.b = sgn * m;
         default: pl.c = sgn * m;
      endcase
      pl.d = coef_type'(off);
      return pl;
   endfunction

   // Loads a complete random box into frustum f, the first five planes in shuffled order.
   function automatic void build_box(int f);
      int        order[5];
      int        j;
      int        t;
      plane_type pl;
      for (int k = 0; k < 3; k++) begin
         box_c[f][k] = int'($urandom_range(12000)) - 6000;
         box_h[f][k] = 1 + $urandom_range(3999);
      end
      box_known[f] = 1'b1;
      for (int i = 0; i < 5; i++) order[i] = i;
      for (int i = 4; i > 0; i--) begin
         j = $urandom_range(i);
         t = order[i];
         order[i] = order[j];
         order[j] = t;
      end
      for (int i = 0; i < PLANES; i++) begin
         pl = box_plane(f, (i < 5) ? order[i] : PLANES-1, 4096 + $urandom_range(3*UNIT - 4096));
         // Now and then tilt the normal slightly so the faces are not axis aligned.
         if ($urandom_range(3) == 0) begin
            pl.a = pl.a + int'($urandom_range(2047)) - 1024;
            pl.b = pl.b + int'($urandom_range(2047)) - 1024;
            pl.c = pl.c + int'($urandom_range(2047)) - 1024;
         end
         push_load(f, (i < 5) ? order[i] : PLANES-1, pl);
      end
   endfunction

   // A test point in or just around a known box, so that masks come out mixed.
   function automatic void push_near_test();
      int                  f;
      int                  span;
      int                  pos[3];
      logic [RADIUS_W-1:0] rad;
      f = $urandom_range(FRUSTUMS-1);
      for (int tries = 0; tries < 16 && !box_known[f]; tries++)
         f = $urandom_range(FRUSTUMS-1);
      if (!box_known[f]) begin
         push_req(random_req(ACT_TEST));
         return;
      end
      for (int k = 0; k < 3; k++) begin
         span   = box_h[f][k] + box_h[f][k] / 4 + 2;
         pos[k] = (box_c[f][k] + int'($urandom_range(2*span)) - span) * UNIT
                + int'($urandom_range(UNIT-1)) - UNIT/2;
      end
      case ($urandom_range(3))
         0:       rad = '0;
         3:       rad = RADIUS_W'($urandom);
         default: rad = RADIUS_W'($urandom_range(box_h[f][0] * UNIT / 8));
      endcase
      push_test(pos[0], pos[1], pos[2], rad);
   endfunction

   // Stimulus, then the wait for the last results and the verdict.
   initial begin : stimulus
      int           sel;
      int           f;
      int           reps;
      int           drain_mark;
      cull_req_type r;
      drain_mark = 400;

      // Nothing is valid yet, so the first test sees an empty mask.
      push_test(0, 0, 0, '0);
      // Frustum 0 gets planes at the coefficient extremes.
      push_load(0, 0, '{a: CMIN, b: 0, c: 0, d: CMIN});
      push_load(0, 1, '{a: CMAX, b: 0, c: 0, d: CMIN});
      push_load(0, 2, '{a: 0, b: CMIN, c: 0, d: CMIN});
      push_load(0, 3, '{a: 0, b: CMAX, c: 0, d: CMIN});
      push_load(0, 4, '{a: 0, b: 0, c: CMIN, d: CMIN});
      push_load(0, 5, '{a: 0, b: 0, c: CMAX, d: CMAX});
      // Frustum 7 is the unit box around the origin.
      for (int k = 0; k < 3; k++) begin
         box_c[7][k] = 0;
         box_h[7][k] = 1;
      end
      box_known[7] = 1'b1;
      for (int p = 0; p < PLANES; p++) push_load(7, p, box_plane(7, p, UNIT));
      // Distance equal to the radius still passes; one less fails.
      push_test(0, 0, 0, RMAX);
      push_test(0, 0, 0, RMAX - RADIUS_W'(1));
      push_test(CMIN, CMAX, CMIN, '0);
      push_test(CMAX, CMIN, CMAX, RMAX);
      // Loads of nonexistent planes and the unused action are ignored.
      push_load(0, 6, plane_type'({$urandom, $urandom, $urandom, $urandom}));
      push_load(0, 7, plane_type'({$urandom, $urandom, $urandom, $urandom}));
      push_req(random_req(ACT_NONE));
      // Clear drops every valid bit but keeps the planes; resealing frustum 7 revives it.
      push_req(random_req(ACT_CLEAR));
      push_test(0, 0, 0, RMAX);
      push_load(7, PLANES-1, box_plane(7, PLANES-1, UNIT));
      push_test(0, 0, 0, '0);

      // Random part: mostly well-formed boxes and tests around them, the rest noise.
      while (items_made < TARGET_ITEMS) begin
         if (items_made >= drain_mark || $urandom_range(199) == 0) begin
            drain_next = 1'b1;
            if (items_made >= drain_mark) drain_mark += 600;
         end
         sel = $urandom_range(99);
         if (sel < 12) begin
            build_box($urandom_range(FRUSTUMS-1));
         end else if (sel < 57) begin
            push_near_test();
         end else if (sel < 70) begin
            push_req(random_req(ACT_TEST));
         end else if (sel < 84) begin
            // A short run of arbitrary loads into one frustum. The last plane only goes in
            // once the other five have been written, so no test reads an unwritten plane.
            f    = $urandom_range(FRUSTUMS-1);
            reps = 1 + $urandom_range(3);
            box_known[f] = 1'b0;
            repeat (reps) begin
               r = random_req(ACT_LOAD);
               r.frustum_slot = SLOT_W'(f);
               if (r.plane_slot == PLANES-1)
                  for (int p = 0; p < PLANES-1; p++)
                     if (!plane_written[f*PLANES + p]) r.plane_slot = SLOT_W'(p);
               push_req(r);
            end
         end else if (sel < 88) begin
            push_req(random_req(ACT_CLEAR));
         end else if (sel < 92) begin
            push_req(random_req(ACT_NONE));
         end else begin
            push_near_test();
         end
      end

      // Wait for every request to go out and every mask to come back.
      while (cull_requests.size() != 0 || req_tvalid) @(posedge clock);
      for (int n = 0; n < DRAIN_LIMIT && pending_masks.size() != 0; n++) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_masks.size() != 0) begin
         $display("%0t ns: %0d visible_mask results never arrived, next expected %02h",
                  $time, pending_masks.size(), pending_masks[0]);
         errors += pending_masks.size();
      end
      if (errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // Request driver: predicts on each transfer and offers the next item with random gaps.
   always @(posedge clock) begin : drive_requests
      logic [REQ_DATA_W-1:0] word;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_visibility(on_bus);
            req_xfers <= req_xfers + 1;
         end
         if (!req_tvalid || req_tready) begin
            if (cull_requests.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)
                && !(cull_requests[0].drain_first && pending_masks.size() != 0)) begin
               on_bus = cull_requests.pop_front();
               word = '0;
               word[FRUSTUM_LSB +: SLOT_W]   = on_bus.frustum_slot;
               word[PLANE_LSB +: SLOT_W]     = on_bus.plane_slot;
               word[COEF_A_LSB +: COEF_W]    = on_bus.plane.a;
               word[COEF_B_LSB +: COEF_W]    = on_bus.plane.b;
               word[COEF_C_LSB +: COEF_W]    = on_bus.plane.c;
               word[COEF_D_LSB +: COEF_W]    = on_bus.plane.d;
               word[POINT_X_LSB +: COEF_W]   = on_bus.point_x;
               word[POINT_Y_LSB +: COEF_W]   = on_bus.point_y;
               word[POINT_Z_LSB +: COEF_W]   = on_bus.point_z;
               word[RADIUS_LSB +: RADIUS_W]  = on_bus.radius;
               req_tdata  <= word;
               req_tuser  <= on_bus.action;
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Long receiver hold-off once traffic is under way, so the unit fills and stalls.
   initial begin : receiver_hold
      wait (req_xfers >= HOLD_AT);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   // Result monitor: checks each transfer against the oldest expected mask.
   always @(posedge clock) begin : watch_results
      logic [MASK_W-1:0] want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_masks.size() == 0) begin
               $display("%0t ns: visible_mask expected none, actual %02h", $time, rsp_tdata);
               errors++;
            end else begin
               want = pending_masks.pop_front();
               if (rsp_tdata !== want) begin
                  $display("%0t ns: visible_mask expected %02h, actual %02h",
                           $time, want, rsp_tdata);
                  errors++;
               end
            end
         end
         rsp_tready <= !rsp_hold && (calm || $urandom_range(99) >= IDLE_PCT);
      end
   end

   // Hard limit on the run.
   initial begin : watchdog
      #(TIMEOUT_NS);
      $display("Regression FAIL");
      $finish;
   end

endmodule
